@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rds_pkg.sv @@
`timescale 1ns / 1ps
package rds_pkg;
   localparam int MaxVoxels  = 32768;
   localparam int MaxExtent  = 64;
   localparam int AddrW      = 15;
   localparam int ValW       = 17;
   localparam int ExtW       = 7;
   localparam logic [ValW-1:0] OneQ16 = 17'd65536;

   localparam logic [2:0] CSR_SIZE_X = 3'd0;
   localparam logic [2:0] CSR_SIZE_Y = 3'd1;
   localparam logic [2:0] CSR_SIZE_Z = 3'd2;
   localparam logic [2:0] CSR_FIT    = 3'd3;
   localparam logic [2:0] CSR_DIFW   = 3'd4;
   localparam logic [2:0] CSR_RATE   = 3'd5;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   // Clamp an extent register to its effective range.
   function automatic logic [ExtW-1:0] eff_extent(input logic [ExtW-1:0] s);
      logic [ExtW-1:0] r;
      r = s;
      if (s == '0) r = ExtW'(1);
      else if (s > ExtW'(MaxExtent)) r = ExtW'(MaxExtent);
      return r;
   endfunction
endpackage

@@ rtl/rds_mac.sv @@
`timescale 1ns / 1ps
// Shared signed multiplier with registered operands, followed by a
// registered accumulator. A 36x36 product is formed from the two 18-bit
// halves of operand b, low half first; done is raised once the high half is added.
module rds_mac (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,     // load operands
   input  logic signed [35:0] op_a,
   input  logic signed [35:0] op_b,
   output logic               done,
   output logic signed [71:0] product
);
   logic signed [35:0] a_ff;
   logic signed [35:0] b_ff;
   logic [1:0]         phase_ff;
   logic [1:0]         phase_in;
   logic signed [71:0] acc_ff;
   logic signed [71:0] acc_in;
   logic signed [54:0] part;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      part     = '0;
      if (start) begin
         phase_in = 2'd1;
         acc_in   = '0;
      end else if (phase_ff == 2'd1) begin
         part     = a_ff * $signed({1'b0, b_ff[17:0]});
         acc_in   = 72'(part);
         phase_in = 2'd2;
      end else if (phase_ff == 2'd2) begin
         part     = a_ff * $signed(b_ff[35:18]);
         acc_in   = acc_ff + (72'(part) <<< 18);
         phase_in = 2'd3;
      end else if (phase_ff == 2'd3) begin
         phase_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
      end else begin
         phase_ff <= phase_in;
      end
      acc_ff <= acc_in;
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
   end

   assign done    = (phase_ff == 2'd3);
   assign product = acc_ff;
endmodule

@@ rtl/reaction_diffusion_3d_sweep.sv @@
`timescale 1ns / 1ps
// Load request: written in S_LOAD after acceptance, ready again back in S_IDLE.
// Update request: reads (S_READ), diffusion rereads (S_WAIT), 8 products on one shared
// multiplier (S_FIT), then S_CALC, S_WRITE, S_RESP; a new request waits for S_IDLE. The first
// update after an extent write passes S_COORD to recover the voxel coordinates, unless the
// sweep restarts, and a full response register holds the sequencer in its last state.
// Synchronous active-high reset clears control, sweep position and configuration, not memory.
`include "assert_macros.svh"
module reaction_diffusion_3d_sweep (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // voxel_index[14:0], voxel_value[31:15]
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // new_value[16:0], updated_index[31:17]
   output logic        rsp_tlast,   // sweep_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   localparam int AW = rds_pkg::AddrW;
   localparam int VW = rds_pkg::ValW;
   localparam int EW = rds_pkg::ExtW;

   // Sequencer states.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;  // issue neighbor reads
   localparam logic [3:0] S_FIT   = 4'd2;  // products for fit terms and the update step
   localparam logic [3:0] S_WAIT  = 4'd3;
   localparam logic [3:0] S_CALC  = 4'd4;
   localparam logic [3:0] S_WRITE = 4'd5;
   localparam logic [3:0] S_RESP  = 4'd6;
   localparam logic [3:0] S_LOAD  = 4'd7;
   localparam logic [3:0] S_COORD = 4'd8;  // rebuild coordinates by subtraction

   // Configuration registers.
   logic [EW-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [63:0]   fit_ff;
   logic [59:0]   difw_ff;
   logic [15:0]   rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= EW'(32);
         size_y_ff <= EW'(32);
         size_z_ff <= EW'(32);
         fit_ff    <= '0;
         difw_ff   <= '0;
         rate_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            rds_pkg::CSR_SIZE_X: size_x_ff <= csr_data[EW-1:0];
            rds_pkg::CSR_SIZE_Y: size_y_ff <= csr_data[EW-1:0];
            rds_pkg::CSR_SIZE_Z: size_z_ff <= csr_data[EW-1:0];
            rds_pkg::CSR_FIT:    fit_ff    <= csr_data;
            rds_pkg::CSR_DIFW:   difw_ff   <= csr_data[59:0];
            rds_pkg::CSR_RATE:   rate_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // Effective extents; sx*sy and the voxel count are fixed-width products of
   // narrow values.
   logic [EW-1:0] sx, sy, sz;
   logic [13:0]   plane;
   logic [20:0]   total_raw;
   logic [15:0]   total;
   assign sx        = rds_pkg::eff_extent(size_x_ff);
   assign sy        = rds_pkg::eff_extent(size_y_ff);
   assign sz        = rds_pkg::eff_extent(size_z_ff);
   assign plane     = sx * sy;
   assign total_raw = plane * sz;
   assign total     = (total_raw > 21'(rds_pkg::MaxVoxels)) ?
                      16'(rds_pkg::MaxVoxels) : total_raw[15:0];

   // Voxel memory, single port, registered read.
   logic [VW-1:0] mem [rds_pkg::MaxVoxels];
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [VW-1:0] mem_wdata;
   logic [VW-1:0] mem_rdata_ff;
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_addr];
   end

   // Control and datapath registers.
   logic [3:0]    state_ff, state_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [AW-1:0] pos_ff, pos_in;     // sweep position
   logic [AW-1:0] p_ff, p_in;         // voxel being updated
   logic [AW-1:0] rem_ff, rem_in;     // remainder while rebuilding coordinates
   logic [EW-1:0] ci_ff, ci_in, cj_ff, cj_in, ck_ff, ck_in; // coordinates
   logic [6:0]    nbv_ff, nbv_in;     // neighbor valid flags, bit 6 = center
   logic [VW-1:0] c_ff, c_in;
   logic signed [31:0] dif_ff, dif_in;   // diffusion sum, Q.24
   logic signed [35:0] fit1_ff, fit1_in; // Q.27
   logic signed [35:0] fit2_ff, fit2_in;
   logic signed [71:0] acc_ff, acc_in;   // scratch: Q.43, then Q.27, finally the Q.16 step
   logic [AW-1:0] ld_addr_ff, ld_addr_in;
   logic [VW-1:0] ld_val_ff, ld_val_in;
   logic [VW-1:0] nv_ff, nv_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          coord_stale_ff;     // extents changed since coordinates were valid
   logic          coord_clear;

   // Shared multiplier.
   logic               mul_start;
   logic signed [35:0] mul_a, mul_b;
   logic               mul_done;
   logic signed [71:0] mul_p;
   logic               busy_mul_ff;

   rds_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   // Neighbor address and valid for read slot n (0..5), slot 6 is the center.
   logic [AW-1:0] rd_addr;
   logic          rd_ok;
   logic [16:0]   pw;
   assign pw = 17'(p_ff);
   always_comb begin
      rd_addr = p_ff;
      rd_ok   = 1'b1;
      unique case (cnt_ff)
         4'd0: begin rd_addr = p_ff - AW'(1); rd_ok = (ci_ff != '0); end
         4'd1: begin
            rd_addr = p_ff + AW'(1);
            rd_ok = (ci_ff + EW'(1) < sx) && (pw + 17'd1 < 17'(total));
         end
         4'd2: begin rd_addr = p_ff - AW'(sx); rd_ok = (cj_ff != '0); end
         4'd3: begin
            rd_addr = p_ff + AW'(sx);
            rd_ok = (cj_ff + EW'(1) < sy) && (pw + 17'(sx) < 17'(total));
         end
         4'd4: begin rd_addr = p_ff - AW'(plane); rd_ok = (ck_ff != '0); end
         4'd5: begin
            rd_addr = p_ff + AW'(plane);
            rd_ok = (ck_ff + EW'(1) < sz) && (pw + 17'(plane) < 17'(total));
         end
         default: begin rd_addr = p_ff; rd_ok = 1'b1; end
      endcase
   end

   // Coefficient selection.
   logic signed [15:0] cf0, cf1, cf2, cf3;
   assign cf0 = fit_ff[15:0];
   assign cf1 = fit_ff[31:16];
   assign cf2 = fit_ff[47:32];
   assign cf3 = fit_ff[63:48];

   logic signed [35:0] cs, oms;
   assign cs  = 36'(c_ff);
   assign oms = 36'(rds_pkg::OneQ16) - cs;

   // Round-half-up shifts (floor of value plus half).
   logic signed [71:0] t16, t27;
   logic signed [71:0] d27_full;
   logic signed [71:0] step_full;
   logic signed [19:0] nvs;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      p_in         = p_ff;
      rem_in       = rem_ff;
      ci_in        = ci_ff;
      cj_in        = cj_ff;
      ck_in        = ck_ff;
      nbv_in       = nbv_ff;
      c_in         = c_ff;
      dif_in       = dif_ff;
      fit1_in      = fit1_ff;
      fit2_in      = fit2_ff;
      acc_in       = acc_ff;
      ld_addr_in   = ld_addr_ff;
      ld_val_in    = ld_val_ff;
      nv_in        = nv_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      coord_clear  = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = rd_addr;
      mem_wdata    = nv_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      t16          = '0;
      t27          = '0;
      d27_full     = '0;
      step_full    = '0;
      nvs          = '0;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == rds_pkg::OP_LOAD) begin
                  ld_addr_in = req_tdata[AW-1:0];
                  ld_val_in  = (req_tdata[31:15] > rds_pkg::OneQ16) ?
                               rds_pkg::OneQ16 : req_tdata[31:15];
                  state_in   = S_LOAD;
               end else begin
                  // Restart the sweep when the volume shrank below it.
                  if (16'(pos_ff) >= total) begin
                     p_in        = '0;
                     ci_in       = '0;
                     cj_in       = '0;
                     ck_in       = '0;
                     coord_clear = 1'b1;
                     state_in    = S_READ;
                  end else begin
                     p_in = pos_ff;
                     // After an extent change the kept coordinates no longer
                     // match the position, so they are rebuilt first.
                     if (coord_stale_ff) begin
                        rem_in   = pos_ff;
                        ci_in    = '0;
                        cj_in    = '0;
                        ck_in    = '0;
                        state_in = S_COORD;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  cnt_in   = 4'd0;
                  dif_in   = '0;
               end
            end
         end
         S_COORD: begin
            // cnt 0 strips whole planes (z), cnt 1 whole rows (y); the rest is x.
            if (cnt_ff == 4'd0) begin
               if (rem_ff >= AW'(plane)) begin
                  rem_in = rem_ff - AW'(plane);
                  ck_in  = ck_ff + EW'(1);
               end else begin
                  cnt_in = 4'd1;
               end
            end else begin
               if (rem_ff >= AW'(sx)) begin
                  rem_in = rem_ff - AW'(sx);
                  cj_in  = cj_ff + EW'(1);
               end else begin
                  ci_in       = rem_ff[EW-1:0];
                  cnt_in      = 4'd0;
                  coord_clear = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         S_LOAD: begin
            mem_we    = 1'b1;
            mem_addr  = ld_addr_ff;
            mem_wdata = ld_val_ff;
            state_in  = S_IDLE;
         end
         S_READ: begin
            // cnt 0..6 issues reads (6 = center) and records valid flags; the registered
            // center data is taken into c at cnt 7, which drains.
            if (cnt_ff <= 4'd6) nbv_in[cnt_ff[2:0]] = rd_ok;
            if (cnt_ff == 4'd7) c_in = mem_rdata_ff;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd7) begin
               cnt_in   = 4'd0;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // Reread neighbors one at a time for the diffusion sum; the center
            // is now known. cnt 0..5 issue, 1..6 consume.
            if (cnt_ff >= 4'd1 && cnt_ff <= 4'd6) begin
               if (nbv_ff[3'(cnt_ff - 4'd1)])
                  dif_in = dif_ff + $signed({22'd0, difw_ff[10*(3'(cnt_ff-4'd1)) +: 10]})
                           * ($signed({15'd0, mem_rdata_ff}) - $signed({15'd0, c_ff}));
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd6) begin
               cnt_in   = 4'd0;
               state_in = S_FIT;
            end
         end
         S_FIT: begin
            // Products: 0 C0*c, 1 C1*om, 2 C2*c, 3 C3*om, 4 c*fit1, 5 om*fit2,
            // 6 c*diff27, 7 rate*d27. Each start is followed by its done.
            if (!busy_mul_ff) begin
               mul_start = 1'b1;
               unique case (cnt_ff[2:0])
                  3'd0: begin mul_a = 36'(cf0); mul_b = cs;  end
                  3'd1: begin mul_a = 36'(cf1); mul_b = oms; end
                  3'd2: begin mul_a = 36'(cf2); mul_b = cs;  end
                  3'd3: begin mul_a = 36'(cf3); mul_b = oms; end
                  3'd4: begin mul_a = cs;  mul_b = fit1_ff; end
                  3'd5: begin mul_a = oms; mul_b = fit2_ff; end
                  3'd6: begin mul_a = cs;  mul_b = acc_ff[35:0]; end
                  default: begin mul_a = 36'(rate_ff); mul_b = acc_ff[35:0]; end
               endcase
            end
            if (mul_done) begin
               cnt_in = cnt_ff + 4'd1;
               unique case (cnt_ff[2:0])
                  3'd0: fit1_in = mul_p[35:0];
                  3'd1: fit1_in = fit1_ff + mul_p[35:0];
                  3'd2: fit2_in = mul_p[35:0];
                  3'd3: fit2_in = fit2_ff + mul_p[35:0];
                  3'd4: acc_in  = mul_p;
                  3'd5: begin
                     // diff27 = round((fit1<<16 - avg) >> 16)
                     t16    = (72'(fit1_ff) <<< 16) - (acc_ff + mul_p) + 72'sd32768;
                     acc_in = t16 >>> 16;
                  end
                  3'd6: begin
                     t16      = mul_p + (72'(dif_ff) <<< 19) + 72'sd32768;
                     d27_full = t16 >>> 16;
                     acc_in   = d27_full;
                  end
                  default: begin
                     t27       = mul_p + (72'sd1 <<< 26);
                     step_full = t27 >>> 27;
                     acc_in    = step_full;
                     state_in  = S_CALC;
                  end
               endcase
            end
         end
         S_CALC: begin
            if (acc_ff > 72'sd200000) nvs = 20'sd200000;
            else if (acc_ff < -72'sd200000) nvs = -20'sd200000;
            else nvs = 20'(acc_ff);
            nvs = nvs + $signed({3'd0, c_ff});
            if (nvs < 0) nv_in = '0;
            else if (nvs > $signed({3'd0, rds_pkg::OneQ16})) nv_in = rds_pkg::OneQ16;
            else nv_in = nvs[VW-1:0];
            last_in  = (17'(p_ff) + 17'd1 >= 17'(total));
            state_in = S_WRITE;
         end
         S_WRITE: begin
            mem_we    = 1'b1;
            mem_addr  = p_ff;
            mem_wdata = nv_ff;
            if (last_ff) begin
               pos_in = '0;
               ci_in  = '0;
               cj_in  = '0;
               ck_in  = '0;
            end else begin
               pos_in = p_ff + AW'(1);
               if (ci_ff + EW'(1) >= sx) begin
                  ci_in = '0;
                  if (cj_ff + EW'(1) >= sy) begin
                     cj_in = '0;
                     ck_in = ck_ff + EW'(1);
                  end else begin
                     cj_in = cj_ff + EW'(1);
                  end
               end else begin
                  ci_in = ci_ff + EW'(1);
               end
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            // The response is copied into its own register so that the next
            // request can start while this one still waits to be taken.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {p_ff, nv_ff};
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // The multiplier is busy from its start until its done.
   always_ff @(posedge clock) begin
      if (reset) busy_mul_ff <= 1'b0;
      else if (mul_start) busy_mul_ff <= 1'b1;
      else if (mul_done) busy_mul_ff <= 1'b0;
   end

   // Any extent write makes the kept coordinates suspect.
   always_ff @(posedge clock) begin
      if (reset) begin
         coord_stale_ff <= 1'b0;
      end else if (csr_valid && (csr_index == rds_pkg::CSR_SIZE_X ||
                                 csr_index == rds_pkg::CSR_SIZE_Y ||
                                 csr_index == rds_pkg::CSR_SIZE_Z)) begin
         coord_stale_ff <= 1'b1;
      end else if (coord_clear) begin
         coord_stale_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         ci_ff        <= '0;
         cj_ff        <= '0;
         ck_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         ci_ff        <= ci_in;
         cj_ff        <= cj_in;
         ck_ff        <= ck_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff        <= p_in;
      rem_ff      <= rem_in;
      nbv_ff      <= nbv_in;
      c_ff        <= c_in;
      dif_ff      <= dif_in;
      fit1_ff     <= fit1_in;
      fit2_ff     <= fit2_in;
      acc_ff      <= acc_in;
      ld_addr_ff  <= ld_addr_in;
      ld_val_ff   <= ld_val_in;
      nv_ff       <= nv_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Center reads during S_READ land in c at cnt 7 (issued at cnt 6).
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A response only appears after the write-back state.
   `ASSERT_NEXT(a_rsp_after_write, clock, reset,
      (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready), rsp_tvalid,
      "response not raised after write-back")
   // A new request is never taken while the sequencer is busy.
   `ASSERT_IMPLIES(a_ready_idle, clock, reset, req_tready, state_ff == S_IDLE,
      "ready outside idle")
   // Response value stays within one.
   `ASSERT_IMPLIES(a_val_range, clock, reset, rsp_tvalid,
      rsp_data_ff[VW-1:0] <= rds_pkg::OneQ16, "response above one")
endmodule
